[hdl/stok_pkg.sv]
// Shared types, token and error codes, keyword table and byte classes of the source tokenizer.
package stok_pkg;

  localparam int POSITION_BITS   = 24;
  localparam int KEYWORD_MAX_LEN = 8;
  localparam int FIELD_BITS      = 24;
  localparam int KW_COUNT        = 39;
  localparam int KW_CHARS        = 8;
  localparam int OQ_DEPTH        = 8;
  localparam int MAX_RESULTS     = 3;

  typedef logic [6:0]            kind_t;
  typedef logic [2:0]            err_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  localparam kind_t K_LPAREN = 7'd0,  K_RPAREN = 7'd1,  K_LBRACE = 7'd2,  K_RBRACE = 7'd3;
  localparam kind_t K_LBRACK = 7'd4,  K_RBRACK = 7'd5,  K_SEMI   = 7'd6,  K_COMMA  = 7'd7;
  localparam kind_t K_DOT    = 7'd8,  K_STAR   = 7'd9,  K_QUEST  = 7'd10, K_AT     = 7'd11;
  localparam kind_t K_CARET  = 7'd12, K_PERCENT = 7'd13, K_COLON = 7'd14, K_SCOPE  = 7'd15;
  localparam kind_t K_ASSIGN = 7'd16, K_EQ     = 7'd17, K_FATARROW = 7'd18, K_NE   = 7'd19;
  localparam kind_t K_AMP    = 7'd20, K_ANDAND = 7'd21, K_BAR    = 7'd22, K_OROR   = 7'd23;
  localparam kind_t K_TILDE  = 7'd24, K_TILDEGT = 7'd25, K_LT    = 7'd26, K_LTTILDE = 7'd27;
  localparam kind_t K_SHL    = 7'd28, K_LE     = 7'd29, K_GT     = 7'd30, K_SHR    = 7'd31;
  localparam kind_t K_GE     = 7'd32, K_PLUS   = 7'd33, K_INC    = 7'd34, K_MINUS  = 7'd35;
  localparam kind_t K_DEC    = 7'd36, K_RARROW = 7'd37, K_SLASH  = 7'd38, K_INT    = 7'd39;
  localparam kind_t K_FLOAT  = 7'd40, K_STR    = 7'd41, K_IDENT  = 7'd42, K_KW0    = 7'd43;
  localparam kind_t K_END    = 7'd82, K_ERROR  = 7'd0;

  localparam err_t E_NONE = 3'd0, E_BANG = 3'd1, E_CHAR = 3'd2, E_HEX = 3'd3, E_STRING = 3'd4;

  localparam logic CFG_FIRST_LINE   = 1'b0;
  localparam logic CFG_FIRST_COLUMN = 1'b1;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_hit_t;

  typedef struct packed {
    kind_t  kind;
    field_t off;
    field_t len;
    field_t ln;
    field_t col;
    err_t   err;
    logic   last;
  } res_t;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "spell", "sigil", "rank", "legion", "leyline", "portline", "grimoire",
    "pact", "conjure", "endless", "warden", "yield", "shatter", "surge",
    "fore", "whirl", "if", "elif", "else", "own", "divine", "destined",
    "stance", "ruin", "mark16", "mark32", "soul16", "soul32", "addr", "flow",
    "rune", "oath", "scroll", "abyss", "kept", "forsaken", "deck", "tuple",
    "cast"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd5, 4'd4, 4'd6, 4'd7, 4'd8, 4'd8,
    4'd4, 4'd7, 4'd7, 4'd6, 4'd5, 4'd7, 4'd5,
    4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd8,
    4'd6, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8, 4'd4, 4'd5,
    4'd4
  };

  function automatic logic is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_wordch(input logic [7:0] b);
    return is_alpha(b) || is_dig(b) || b == "_";
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || b == "\t" || b == "\r" || b == "\n";
  endfunction

  function automatic kind_hit_t single_kind(input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = K_LPAREN;
    case (b)
      "(": r.kind = K_LPAREN;
      ")": r.kind = K_RPAREN;
      "{": r.kind = K_LBRACE;
      "}": r.kind = K_RBRACE;
      "[": r.kind = K_LBRACK;
      "]": r.kind = K_RBRACK;
      ";": r.kind = K_SEMI;
      ",": r.kind = K_COMMA;
      ".": r.kind = K_DOT;
      "*": r.kind = K_STAR;
      "?": r.kind = K_QUEST;
      "@": r.kind = K_AT;
      "^": r.kind = K_CARET;
      "%": r.kind = K_PERCENT;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t alone_kind(input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = K_COLON;
    case (b)
      ":": r.kind = K_COLON;
      "=": r.kind = K_ASSIGN;
      "&": r.kind = K_AMP;
      "|": r.kind = K_BAR;
      "~": r.kind = K_TILDE;
      "<": r.kind = K_LT;
      ">": r.kind = K_GT;
      "+": r.kind = K_PLUS;
      "-": r.kind = K_MINUS;
      "/": r.kind = K_SLASH;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b0;
    r.kind = K_SCOPE;
    case (a)
      ":": if (b == ":") r = '{1'b1, K_SCOPE};
      "=": begin
        if (b == "=") r = '{1'b1, K_EQ};
        else if (b == ">") r = '{1'b1, K_FATARROW};
      end
      "!": if (b == "=") r = '{1'b1, K_NE};
      "&": if (b == "&") r = '{1'b1, K_ANDAND};
      "|": if (b == "|") r = '{1'b1, K_OROR};
      "~": if (b == ">") r = '{1'b1, K_TILDEGT};
      "<": begin
        if (b == "~") r = '{1'b1, K_LTTILDE};
        else if (b == "<") r = '{1'b1, K_SHL};
        else if (b == "=") r = '{1'b1, K_LE};
      end
      ">": begin
        if (b == ">") r = '{1'b1, K_SHR};
        else if (b == "=") r = '{1'b1, K_GE};
      end
      "+": if (b == "+") r = '{1'b1, K_INC};
      "-": begin
        if (b == "-") r = '{1'b1, K_DEC};
        else if (b == ">") r = '{1'b1, K_RARROW};
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[hdl/source_tokenizer_unit.sv]
// Source tokenizer top level: byte scanner, keyword match and result queue.
//
//   channel  | signals                                              | dir
//   ---------+------------------------------------------------------+-----
//   input    | in_valid in_ready char_byte has_byte end_of_source   | in
//   result   | out_valid out_ready token_kind text_offset           | out
//            | text_length line_number start_column error_code      |
//            | last_of_run                                          |
//   config   | cfg_write cfg_index cfg_data                         | in
//
// One input transfer per cycle; the scanner state and up to three results are
// computed in that cycle and written to an eight-entry result queue.
// Results leave the queue one per cycle while out_ready is high; input stalls
// while fewer than three queue entries are free. Reset needs no clearing pass.
module source_tokenizer_unit #(
  parameter int P    = stok_pkg::POSITION_BITS,
  parameter int KMAX = stok_pkg::KEYWORD_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 char_byte,
  input  logic                       has_byte,
  input  logic                       end_of_source,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stok_pkg::kind_t            token_kind,
  output stok_pkg::field_t           text_offset,
  output stok_pkg::field_t           text_length,
  output stok_pkg::field_t           line_number,
  output stok_pkg::field_t           start_column,
  output stok_pkg::err_t             error_code,
  output logic                       last_of_run,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [stok_pkg::FIELD_BITS-1:0] cfg_data
);

  typedef logic [P-1:0] pos_t;

  localparam int WLW  = $clog2(KMAX + 2);
  localparam int WIW  = $clog2(KMAX);
  localparam int NCMP = (KMAX < stok_pkg::KW_CHARS) ? KMAX : stok_pkg::KW_CHARS;
  localparam int QAW  = $clog2(stok_pkg::OQ_DEPTH);
  localparam logic [32:0] PMAX33 = (33'd1 << P) - 33'd1;
  localparam pos_t PMAX = '1;

  localparam logic [3:0] M_IDLE = 4'd0, M_WORD = 4'd1, M_ZERO = 4'd2, M_DEC = 4'd3;
  localparam logic [3:0] M_HEXX = 4'd4, M_HEX = 4'd5, M_DOT = 4'd6, M_FRAC = 4'd7;
  localparam logic [3:0] M_STR = 4'd8, M_ESC = 4'd9, M_COMMENT = 4'd10, M_OP = 4'd11;
  localparam logic [3:0] M_ERR = 4'd12;

  function automatic pos_t clamp(input stok_pkg::field_t v);
    if ({9'b0, v} > PMAX33) return PMAX;
    return pos_t'(v);
  endfunction

  function automatic pos_t inc(input pos_t v);
    return (v == PMAX) ? v : v + pos_t'(1);
  endfunction

  function automatic stok_pkg::res_t mk(input stok_pkg::kind_t k, input pos_t o, input pos_t l,
                                        input pos_t ln, input pos_t c, input stok_pkg::err_t e);
    stok_pkg::res_t r;
    r.kind = k;
    r.off  = stok_pkg::field_t'(o);
    r.len  = stok_pkg::field_t'(l);
    r.ln   = stok_pkg::field_t'(ln);
    r.col  = stok_pkg::field_t'(c);
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  logic [3:0]       mode, mode_next;
  logic [7:0]       pend, pend_next;
  logic [7:0]       wbuf [KMAX];
  logic [WLW-1:0]   wlen, wlen_next;
  pos_t             tstart, tstart_next, tcol, tcol_next, boff, boff_next;
  pos_t             line, line_next, col, col_next, sline, sline_next;
  pos_t             doff, doff_next, dcol, dcol_next;
  stok_pkg::field_t first_line, first_column;

  logic             wb_we;
  logic [WIW-1:0]   wb_idx;
  logic             acc, pop, do_begin, fresh;
  logic [1:0]       n;
  stok_pkg::res_t   res [stok_pkg::MAX_RESULTS];

  stok_pkg::kind_t    wkind;
  logic               kw_hit, kw_eq;
  stok_pkg::kind_hit_t sk, ak, pk, pend_ak;
  pos_t               soff, slen;

  logic [3:0]       b_mode;
  logic             b_emit, b_start, b_pend, b_str, b_word;
  stok_pkg::res_t   b_res;

  stok_pkg::res_t   oq [stok_pkg::OQ_DEPTH];
  logic [QAW-1:0]   wp, rp;
  logic [QAW:0]     count;

  assign acc      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;
  assign in_ready = (32'(count) <= stok_pkg::OQ_DEPTH - stok_pkg::MAX_RESULTS);
  assign fresh    = (boff == '0) && (mode == M_IDLE);

  assign sk      = stok_pkg::single_kind(char_byte);
  assign ak      = stok_pkg::alone_kind(char_byte);
  assign pk      = stok_pkg::pair_kind(pend, char_byte);
  assign pend_ak = stok_pkg::alone_kind(pend);
  assign soff    = inc(tstart);
  assign slen    = (boff > soff) ? boff - soff : '0;

  always_comb begin
    wkind  = stok_pkg::K_IDENT;
    kw_hit = 1'b0;
    kw_eq  = 1'b0;
    for (int k = 0; k < stok_pkg::KW_COUNT; k++) begin
      kw_eq = (32'(wlen) <= KMAX) && (32'(wlen) == 32'(stok_pkg::KW_LEN[k]));
      for (int i = 0; i < NCMP; i++) begin
        if (i < 32'(stok_pkg::KW_LEN[k]) &&
            wbuf[i] != stok_pkg::KW_TEXT[k][8*(32'(stok_pkg::KW_LEN[k])-1-i) +: 8])
          kw_eq = 1'b0;
      end
      if (kw_eq && !kw_hit) begin
        kw_hit = 1'b1;
        wkind  = stok_pkg::K_KW0 + 7'(k);
      end
    end
  end

  always_comb begin
    b_mode  = M_IDLE;
    b_emit  = 1'b0;
    b_res   = mk(stok_pkg::K_ERROR, '0, '0, '0, '0, stok_pkg::E_NONE);
    b_start = 1'b0;
    b_pend  = 1'b0;
    b_str   = 1'b0;
    b_word  = 1'b0;
    if (stok_pkg::is_blank(char_byte)) begin
      b_mode = M_IDLE;
    end else if (sk.hit) begin
      b_emit = 1'b1;
      b_res  = mk(sk.kind, boff, pos_t'(1), line, col, stok_pkg::E_NONE);
    end else begin
      b_start = 1'b1;
      if (char_byte == "!" || ak.hit) begin
        b_mode = M_OP;
        b_pend = 1'b1;
      end else if (char_byte == "\"") begin
        b_mode = M_STR;
        b_str  = 1'b1;
      end else if (stok_pkg::is_dig(char_byte)) begin
        b_mode = (char_byte == "0") ? M_ZERO : M_DEC;
      end else if (stok_pkg::is_alpha(char_byte) || char_byte == "_") begin
        b_mode = M_WORD;
        b_word = 1'b1;
      end else begin
        b_mode = M_ERR;
        b_emit = 1'b1;
        b_res  = mk(stok_pkg::K_ERROR, '0, '0, line, inc(col), stok_pkg::E_CHAR);
      end
    end
  end

  always_comb begin
    mode_next   = mode;
    pend_next   = pend;
    wlen_next   = wlen;
    wb_we       = 1'b0;
    wb_idx      = '0;
    tstart_next = tstart;
    tcol_next   = tcol;
    sline_next  = sline;
    doff_next   = doff;
    dcol_next   = dcol;
    boff_next   = boff;
    line_next   = line;
    col_next    = col;
    n           = 2'd0;
    do_begin    = 1'b0;
    for (int i = 0; i < stok_pkg::MAX_RESULTS; i++)
      res[i] = mk(stok_pkg::K_ERROR, '0, '0, '0, '0, stok_pkg::E_NONE);

    if (end_of_source) begin
      unique case (mode) inside
        M_WORD: begin
          res[n] = mk(wkind, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
          n = n + 2'd1;
        end
        M_ZERO, M_DEC, M_HEX: begin
          res[n] = mk(stok_pkg::K_INT, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
          n = n + 2'd1;
        end
        M_FRAC: begin
          res[n] = mk(stok_pkg::K_FLOAT, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
          n = n + 2'd1;
        end
        M_HEXX: begin
          res[n] = mk(stok_pkg::K_ERROR, '0, '0, line, col, stok_pkg::E_HEX);
          n = n + 2'd1;
        end
        M_DOT: begin
          res[n] = mk(stok_pkg::K_INT, tstart, doff - tstart, line, tcol, stok_pkg::E_NONE);
          n = n + 2'd1;
          res[n] = mk(stok_pkg::K_DOT, doff, pos_t'(1), line, dcol, stok_pkg::E_NONE);
          n = n + 2'd1;
        end
        M_OP: begin
          if (pend == "!")
            res[n] = mk(stok_pkg::K_ERROR, '0, '0, line, col, stok_pkg::E_BANG);
          else
            res[n] = mk(pend_ak.kind, tstart, pos_t'(1), line, tcol, stok_pkg::E_NONE);
          n = n + 2'd1;
        end
        M_STR, M_ESC: begin
          res[n] = mk(stok_pkg::K_ERROR, '0, '0, sline, tcol, stok_pkg::E_STRING);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = mk(stok_pkg::K_END, boff, '0, line, col, stok_pkg::E_NONE);
      n = n + 2'd1;
      mode_next   = M_IDLE;
      pend_next   = '0;
      wlen_next   = '0;
      tstart_next = '0;
      tcol_next   = '0;
      boff_next   = '0;
      line_next   = clamp(first_line);
      col_next    = clamp(first_column);
      sline_next  = '0;
      doff_next   = '0;
      dcol_next   = '0;
    end else if (has_byte) begin
      unique case (mode)
        M_ERR: ;
        M_IDLE: do_begin = 1'b1;
        M_COMMENT: if (char_byte == "\n") mode_next = M_IDLE;
        M_WORD: begin
          if (stok_pkg::is_wordch(char_byte)) begin
            if (32'(wlen) < KMAX) begin
              wb_we  = 1'b1;
              wb_idx = wlen[WIW-1:0];
            end
            if (32'(wlen) <= KMAX) wlen_next = wlen + WLW'(1);
          end else begin
            res[n] = mk(wkind, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_ZERO, M_DEC: begin
          if (mode == M_ZERO && (char_byte == "x" || char_byte == "X")) begin
            mode_next = M_HEXX;
          end else if (stok_pkg::is_dig(char_byte)) begin
            mode_next = M_DEC;
          end else if (char_byte == ".") begin
            doff_next = boff;
            dcol_next = col;
            mode_next = M_DOT;
          end else begin
            res[n] = mk(stok_pkg::K_INT, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_HEXX: begin
          if (stok_pkg::is_hex(char_byte)) begin
            mode_next = M_HEX;
          end else begin
            res[n] = mk(stok_pkg::K_ERROR, '0, '0, line, col, stok_pkg::E_HEX);
            n = n + 2'd1;
            mode_next = M_ERR;
          end
        end
        M_HEX: begin
          if (!stok_pkg::is_hex(char_byte)) begin
            res[n] = mk(stok_pkg::K_INT, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_DOT: begin
          if (stok_pkg::is_dig(char_byte)) begin
            mode_next = M_FRAC;
          end else begin
            res[n] = mk(stok_pkg::K_INT, tstart, doff - tstart, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            res[n] = mk(stok_pkg::K_DOT, doff, pos_t'(1), line, dcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_FRAC: begin
          if (!stok_pkg::is_dig(char_byte)) begin
            res[n] = mk(stok_pkg::K_FLOAT, tstart, boff - tstart, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_STR: begin
          if (char_byte == "\"") begin
            res[n] = mk(stok_pkg::K_STR, soff, slen, line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (char_byte == "\\") begin
            mode_next = M_ESC;
          end
        end
        M_ESC: mode_next = M_STR;
        M_OP: begin
          if (pk.hit) begin
            res[n] = mk(pk.kind, tstart, pos_t'(2), line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (pend == "/" && char_byte == "/") begin
            mode_next = M_COMMENT;
          end else if (pend == "!") begin
            res[n] = mk(stok_pkg::K_ERROR, '0, '0, line, col, stok_pkg::E_BANG);
            n = n + 2'd1;
            mode_next = M_ERR;
          end else begin
            res[n] = mk(pend_ak.kind, tstart, pos_t'(1), line, tcol, stok_pkg::E_NONE);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase

      if (do_begin) begin
        mode_next = b_mode;
        if (b_emit) begin
          res[n] = b_res;
          n = n + 2'd1;
        end
        if (b_start) begin
          tstart_next = boff;
          tcol_next   = col;
        end
        if (b_pend) pend_next = char_byte;
        if (b_str) sline_next = line;
        if (b_word) begin
          wb_we     = 1'b1;
          wb_idx    = '0;
          wlen_next = WLW'(1);
        end
      end

      if (mode_next != M_ERR) begin
        if (char_byte == "\n") begin
          line_next = inc(line);
          col_next  = pos_t'(1);
        end else begin
          col_next = inc(col);
        end
        boff_next = inc(boff);
      end
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      pend         <= '0;
      wlen         <= '0;
      tstart       <= '0;
      tcol         <= '0;
      boff         <= '0;
      line         <= pos_t'(1);
      col          <= pos_t'(1);
      sline        <= '0;
      doff         <= '0;
      dcol         <= '0;
      first_line   <= stok_pkg::field_t'(1);
      first_column <= stok_pkg::field_t'(1);
    end else begin
      if (acc) begin
        mode   <= mode_next;
        pend   <= pend_next;
        wlen   <= wlen_next;
        tstart <= tstart_next;
        tcol   <= tcol_next;
        boff   <= boff_next;
        line   <= line_next;
        col    <= col_next;
        sline  <= sline_next;
        doff   <= doff_next;
        dcol   <= dcol_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          stok_pkg::CFG_FIRST_LINE: begin
            first_line <= cfg_data;
            if (fresh && !acc) line <= clamp(cfg_data);
          end
          stok_pkg::CFG_FIRST_COLUMN: begin
            first_column <= cfg_data;
            if (fresh && !acc) col <= clamp(cfg_data);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wb_we) wbuf[wb_idx] <= char_byte;
  end

  // result queue: up to three writes per accepted input, one read per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < stok_pkg::MAX_RESULTS; i++)
        if (i < 32'(n)) oq[wp + QAW'(i)] <= res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (acc) wp <= wp + QAW'(n);
      if (pop) rp <= rp + QAW'(1);
      count <= count + (acc ? (QAW+1)'(n) : '0) - (pop ? (QAW+1)'(1) : '0);
    end
  end

  assign token_kind   = oq[rp].kind;
  assign text_offset  = oq[rp].off;
  assign text_length  = oq[rp].len;
  assign line_number  = oq[rp].ln;
  assign start_column = oq[rp].col;
  assign error_code   = oq[rp].err;
  assign last_of_run  = oq[rp].last;

endmodule
